// ===== design/trs_pkg.sv =====
`timescale 1ns / 1ps

package trs_pkg;

    localparam int CHANNELS    = 4;
    localparam int ROWS        = 64;
    localparam int MAX_RESULTS = 4;

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int DEPTH   = CHANNELS * ROWS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int LOOP_W  = ((ROW_W > 7) ? ROW_W : 7) + 2;

    localparam int TIMER_W = 25;
    localparam int LEN_W   = 24;
    localparam int DUR_W   = 8;
    localparam int SMP_W   = 20;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TIMER_W-1:0] ONE_SAMPLE = TIMER_W'(256);
    localparam logic [LEN_W-1:0]   MIN_LEN    = LEN_W'(256);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ROW_LENGTH = 2'd0,
        REG_LOOP_START = 2'd1,
        REG_LOOP_COUNT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]      freq;
        logic [7:0]       vol;
        logic [DUR_W-1:0] att;
        logic [DUR_W-1:0] sus;
        logic [DUR_W-1:0] dec;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic [LEN_W-1:0] row_length;
        logic [5:0]       loop_start;
        logic [6:0]       loop_count;
    } cfg_t;

endpackage

// ===== design/tracker_row_sequencer.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------
// in        in_valid / in_ready       cmd, cell_channel, cell_row, note_*, *_rows
// out       out_valid / out_ready     voice, play_row, out_*, *_samples, last_trigger
// cfg       APB psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// Steps: write, start, stop and a tick while stopped are handled in the idle
// state; a tick that stays inside the row adds to the timer, then compares it
// against the row length. A row crossing scans the pattern RAM once per channel
// (a read state and a check state each, through the single registered read
// port), walks the trigger mask once more, then makes three passes per triggered
// channel through the one 8x24 multiplier before loading the output register,
// and finally advances the row.
// Reset clears sequencer state, timer, row and the play flag; the pattern RAM
// is not cleared, and the user must write every cell before playback; the block
// itself does not enforce this. in_ready is high only in the idle state. A
// stalled out_ready holds the sequencer in its output step; the last item of a
// row may sit in the output register while the next input item is taken.

module tracker_row_sequencer
    import trs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [1:0]         cell_channel,
    input  logic [5:0]         cell_row,
    input  logic [15:0]        note_frequency,
    input  logic [7:0]         note_volume,
    input  logic [7:0]         attack_rows,
    input  logic [7:0]         sustain_rows,
    input  logic [7:0]         decay_rows,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         voice,
    output logic [5:0]         play_row,
    output logic [15:0]        out_frequency,
    output logic [7:0]         out_volume,
    output logic [19:0]        attack_samples,
    output logic [19:0]        sustain_samples,
    output logic [19:0]        decay_samples,
    output logic               last_trigger,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,     // timer vs row length
        S_SCAN_RD,   // read cell of channel ch
        S_SCAN_CHK,  // note present? build trigger mask
        S_FIND,      // next masked channel
        S_RD,
        S_MUL_A,
        S_MUL_S,
        S_MUL_D,
        S_MUL_W,
        S_PUT,       // load output register
        S_ADVANCE
    } state_t;

    cfg_t cfg;

    trs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t               state_reg,     state_next;
    logic [TIMER_W-1:0]   timer_reg,     timer_next;
    logic [ROW_W-1:0]     row_reg,       row_next;
    logic                 playing_reg,   playing_next;
    logic [CNT_W-1:0]     ch_reg,        ch_next;
    logic [RES_W-1:0]     cnt_reg,       cnt_next;
    logic [CHANNELS-1:0]  mask_reg,      mask_next;
    logic                 out_valid_reg, out_valid_next;

    logic [SMP_W-1:0]     att_reg, sus_reg, dec_reg;

    logic [1:0]           voice_reg;
    logic [5:0]           play_row_reg;
    logic [15:0]          freq_reg;
    logic [7:0]           vol_reg;
    logic [SMP_W-1:0]     att_out_reg, sus_out_reg, dec_out_reg;
    logic                 last_reg;

    // Effective row length: never below one sample.
    logic [LEN_W-1:0]     len;
    assign len = (cfg.row_length < MIN_LEN) ? MIN_LEN : cfg.row_length;

    logic                 in_acc;
    cmd_t                 in_cmd;
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign in_cmd   = cmd_t'(cmd);

    // Pattern RAM: address = channel * ROWS + row.
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    cell_t                ram_wdata;
    logic [CELL_W-1:0]    ram_rdata;
    cell_t                rd_cell;
    logic [CH_W-1:0]      ch_idx;

    assign ch_idx = ch_reg[CH_W-1:0];

    assign ram_we = in_acc && (in_cmd == CMD_WRITE)
                    && (cell_channel < CHANNELS) && (cell_row < ROWS);
    assign ram_waddr = ADDR_W'(ADDR_W'(cell_channel) * ADDR_W'(ROWS) + ADDR_W'(cell_row));
    assign ram_wdata = '{freq: note_frequency, vol: note_volume,
                         att: attack_rows, sus: sustain_rows, dec: decay_rows};
    assign ram_re    = (state_reg == S_SCAN_RD) || (state_reg == S_RD);
    assign ram_raddr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(ROWS) + ADDR_W'(row_reg));
    assign rd_cell   = cell_t'(ram_rdata);

    trs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared scaler; read data holds between reads, so fields feed it directly.
    logic [DUR_W-1:0]     mul_dur;
    logic [SMP_W-1:0]     mul_res;

    always_comb
    begin
        unique case (state_reg)
            S_MUL_S: mul_dur = rd_cell.sus;
            S_MUL_D: mul_dur = rd_cell.dec;
            default: mul_dur = rd_cell.att;
        endcase
    end

    trs_mul u_mul (
        .clk     (clk),
        .dur     (mul_dur),
        .len     (len),
        .samples (mul_res)
    );

    // Row advance: wrap at ROWS, then fold back to loop start past the loop end.
    logic [ROW_W:0]       row_inc;
    logic [ROW_W-1:0]     row_wrap;
    logic [LOOP_W-1:0]    loop_lim;
    logic [ROW_W-1:0]     row_adv;

    assign row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign row_wrap = (row_inc >= ROWS) ? '0 : row_inc[ROW_W-1:0];
    assign loop_lim = LOOP_W'(cfg.loop_start) + LOOP_W'(cfg.loop_count);

    always_comb
    begin
        row_adv = row_wrap;
        if ((LOOP_W'(row_wrap) + LOOP_W'(1)) > loop_lim)
        begin
            row_adv = (cfg.loop_start >= ROWS) ? '0 : ROW_W'(cfg.loop_start);
        end
    end

    logic                 is_last;
    logic                 out_free;
    assign is_last  = ((mask_reg >> ch_idx) >> 1) == '0;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        timer_next     = timer_reg;
        row_next       = row_reg;
        playing_next   = playing_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_cmd)
                        CMD_START:
                        begin
                            row_next     = '0;
                            timer_next   = '0;
                            playing_next = 1'b1;
                        end
                        CMD_STOP:
                        begin
                            playing_next = 1'b0;
                        end
                        CMD_TICK:
                        begin
                            if (playing_reg)
                            begin
                                timer_next = timer_reg + ONE_SAMPLE;
                                state_next = S_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (timer_reg >= {1'b0, len})
                begin
                    timer_next = timer_reg - TIMER_W'(len);
                    ch_next    = '0;
                    cnt_next   = '0;
                    mask_next  = '0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if ((rd_cell.freq != '0) && (cnt_reg < MAX_RESULTS))
                begin
                    mask_next[ch_idx] = 1'b1;
                    cnt_next          = cnt_reg + RES_W'(1);
                end
                if (ch_reg == CNT_W'(CHANNELS - 1))
                begin
                    ch_next    = '0;
                    state_next = S_FIND;
                end
                else
                begin
                    ch_next    = ch_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_FIND:
            begin
                if (ch_reg == CNT_W'(CHANNELS))
                begin
                    state_next = S_ADVANCE;
                end
                else if (mask_reg[ch_idx])
                begin
                    state_next = S_RD;
                end
                else
                begin
                    ch_next = ch_reg + CNT_W'(1);
                end
            end
            S_RD:    state_next = S_MUL_A;
            S_MUL_A: state_next = S_MUL_S;
            S_MUL_S: state_next = S_MUL_D;
            S_MUL_D: state_next = S_MUL_W;
            S_MUL_W: state_next = S_PUT;
            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ch_next        = ch_reg + CNT_W'(1);
                    state_next     = S_FIND;
                end
            end
            S_ADVANCE:
            begin
                row_next   = row_adv;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timer_reg     <= '0;
            row_reg       <= '0;
            playing_reg   <= 1'b0;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            row_reg       <= row_next;
            playing_reg   <= playing_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: each scaled length passes through the multiplier's output register into att_reg, sus_reg or dec_reg.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL_S)
        begin
            att_reg <= mul_res;
        end
        if (state_reg == S_MUL_D)
        begin
            sus_reg <= mul_res;
        end
        if (state_reg == S_MUL_W)
        begin
            dec_reg <= mul_res;
        end
        if ((state_reg == S_PUT) && out_free)
        begin
            voice_reg    <= 2'(ch_idx);
            play_row_reg <= 6'(row_reg);
            freq_reg     <= rd_cell.freq;
            vol_reg      <= rd_cell.vol;
            att_out_reg  <= att_reg;
            sus_out_reg  <= sus_reg;
            dec_out_reg  <= dec_reg;
            last_reg     <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign voice           = voice_reg;
    assign play_row        = play_row_reg;
    assign out_frequency   = freq_reg;
    assign out_volume      = vol_reg;
    assign attack_samples  = att_out_reg;
    assign sustain_samples = sus_out_reg;
    assign decay_samples   = dec_out_reg;
    assign last_trigger    = last_reg;

endmodule

// ===== design/trs_ram.sv =====
`timescale 1ns / 1ps

module trs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/trs_mul.sv =====
`timescale 1ns / 1ps

module trs_mul
    import trs_pkg::*;
(
    input  logic             clk,
    input  logic [DUR_W-1:0] dur,
    input  logic [LEN_W-1:0] len,
    output logic [SMP_W-1:0] samples
);

    // Q4.4 rows times Q16.8 samples, back to whole samples: drop 12 bits.
    logic [DUR_W+LEN_W-1:0] prod;
    logic [SMP_W-1:0]       samples_reg;

    assign prod = DUR_W'(dur) * LEN_W'(len);

    always_ff @(posedge clk)
    begin
        samples_reg <= prod[SMP_W+11:12];
    end

    assign samples = samples_reg;

endmodule

// ===== design/trs_regs.sv =====
`timescale 1ns / 1ps

module trs_regs
    import trs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length <= LEN_W'(11289600);
            cfg_reg.loop_start <= 6'd0;
            cfg_reg.loop_count <= 7'd64;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROW_LENGTH: cfg_reg.row_length <= pwdata[LEN_W-1:0];
                REG_LOOP_START: cfg_reg.loop_start <= pwdata[5:0];
                REG_LOOP_COUNT: cfg_reg.loop_count <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROW_LENGTH: prdata = PDATA_W'(cfg_reg.row_length);
            REG_LOOP_START: prdata = PDATA_W'(cfg_reg.loop_start);
            REG_LOOP_COUNT: prdata = PDATA_W'(cfg_reg.loop_count);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
